[sv/uast_pkg.sv]
// ----------------------------------------------------------------------------
// uast_pkg
// shared types, operation codes and defaults for the unique address set table
// ----------------------------------------------------------------------------
package uast_pkg;

   localparam int SET_DEPTH_DEFAULT = 32;

   localparam int KIND_W  = 2;
   localparam int ADDR_W  = 8;
   localparam int POS_W   = 5;
   localparam int COUNT_W = 5;

   localparam logic [KIND_W-1:0] OP_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] OP_LOOKUP = 2'd2;
   localparam logic [KIND_W-1:0] OP_NEXT   = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [POS_W-1:0]   position;
      logic [ADDR_W-1:0]  address_out;
      logic [COUNT_W-1:0] count;
   } rsp_type;

endpackage

[sv/uast_store.sv]
// ----------------------------------------------------------------------------
// uast_store
// entry memory, one read and one write port, registered read; entries never
// written since reset read as zero
// ----------------------------------------------------------------------------
module uast_store
   import uast_pkg::*;
#(
   parameter int SET_DEPTH = SET_DEPTH_DEFAULT,
   localparam int AW = $clog2(SET_DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [AW-1:0]     rd_addr,
   output logic [ADDR_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [ADDR_W-1:0] wr_data
);

   logic [ADDR_W-1:0]    store_mem [SET_DEPTH];
   logic [SET_DEPTH-1:0] vld_ff;
   logic [ADDR_W-1:0]    data_ff;
   logic                 dvld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      data_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         dvld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         dvld_ff <= vld_ff[rd_addr];
      end
   end

   assign rd_data = dvld_ff ? data_ff : '0;

endmodule

[sv/unique_address_set_table_top.sv]
// ----------------------------------------------------------------------------
// unique_address_set_table_top
// compact set of distinct device addresses with round-robin read
// ----------------------------------------------------------------------------
// A command is taken on a clock edge with start high and busy low; req_data
// carries the kind (insert, remove, lookup, next) and the address.
// Exactly one result per command appears on rsp_data for one cycle with
// rsp_valid high; the receiver cannot hold it off and has no stall path.
// Entries sit in a single-port-read, single-port-write memory with a registered
// read and are scanned one slot per clock cycle.
// Work per command, with n listed entries:
//   next: reads the slot at the read pointer, no scan
//   lookup, insert of a listed address: scan up to the slot when found
//   insert of a new address, miss on lookup or remove: scan of all n entries
//   remove when found: scan up to the slot, then shift the later entries down
// busy stays high until the result is shown; a new command may be taken in
// the cycle the result is on the ports. Reset empties the set, clears the
// read pointer and makes every slot read as zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
module unique_address_set_table_top
   import uast_pkg::*;
#(
   parameter int SET_DEPTH = SET_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(SET_DEPTH);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CMP   = 3'd1;
   localparam logic [2:0] ST_MISS  = 3'd2;
   localparam logic [2:0] ST_SHIFT = 3'd3;
   localparam logic [2:0] ST_NEXT  = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [AW-1:0]     cnt_ff, cnt_in;
   logic [AW-1:0]     rp_ff, rp_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [AW-1:0]     rd_addr;
   logic [ADDR_W-1:0] rd_data;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [ADDR_W-1:0] wr_data;

   logic [AW:0]       idx_p1;
   logic [AW:0]       idx_p2;
   logic [AW:0]       cnt_inc;
   logic [AW:0]       rp_inc;
   logic [AW-1:0]     cnt_dec;

   uast_store #(
      .SET_DEPTH(SET_DEPTH)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign idx_p1  = (AW+1)'(idx_ff) + (AW+1)'(1);
   assign idx_p2  = (AW+1)'(idx_ff) + (AW+1)'(2);
   assign cnt_inc = (AW+1)'(cnt_ff) + (AW+1)'(1);
   assign rp_inc  = (AW+1)'(rp_ff) + (AW+1)'(1);
   assign cnt_dec = cnt_ff - AW'(1);

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      addr_in      = addr_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      rp_in        = rp_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = rd_data;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               kind_in = req_data.kind;
               addr_in = req_data.address;
               idx_in  = '0;
               if (req_data.kind == OP_NEXT) begin
                  rd_addr  = rp_ff;
                  state_in = ST_NEXT;
               end else if (cnt_ff == '0) begin
                  state_in = ST_MISS;
               end else begin
                  rd_addr  = '0;
                  state_in = ST_CMP;
               end
            end
         end

         ST_CMP: begin
            if (rd_data == addr_ff) begin
               rsp_in = '{hit: 1'b0, position: '0, address_out: '0,
                          count: COUNT_W'(cnt_ff)};
               case (kind_ff)
                  OP_LOOKUP: begin
                     rsp_in.hit      = 1'b1;
                     rsp_in.position = POS_W'(idx_ff);
                     rsp_valid_in    = 1'b1;
                     state_in        = ST_IDLE;
                  end
                  OP_REMOVE: begin
                     cnt_in           = cnt_dec;
                     rsp_in.hit       = 1'b1;
                     rsp_in.count     = COUNT_W'(cnt_dec);
                     if (idx_ff < cnt_dec) begin
                        rd_addr  = AW'(idx_p1);
                        state_in = ST_SHIFT;
                     end else begin
                        rsp_valid_in = 1'b1;
                        state_in     = ST_IDLE;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end
               endcase
            end else if (idx_p1 < (AW+1)'(cnt_ff)) begin
               idx_in  = AW'(idx_p1);
               rd_addr = AW'(idx_p1);
            end else begin
               state_in = ST_MISS;
            end
         end

         ST_MISS: begin
            rsp_in = '{hit: 1'b0, position: '0, address_out: '0,
                       count: COUNT_W'(cnt_ff)};
            if (kind_ff == OP_INSERT) begin
               wr_en      = 1'b1;
               wr_addr    = cnt_ff;
               wr_data    = addr_ff;
               rsp_in.hit = 1'b1;
               if (cnt_inc == (AW+1)'(SET_DEPTH)) begin
                  cnt_in       = '0;
                  rsp_in.count = '0;
               end else begin
                  cnt_in       = AW'(cnt_inc);
                  rsp_in.count = COUNT_W'(cnt_inc);
               end
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         ST_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = rd_data;
            idx_in  = AW'(idx_p1);
            if (idx_p2 < (AW+1)'(cnt_ff) + (AW+1)'(1)) begin
               rd_addr = AW'(idx_p2);
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_NEXT: begin
            rsp_in = '{hit: 1'b1, position: POS_W'(rp_ff), address_out: rd_data,
                       count: COUNT_W'(cnt_ff)};
            if (rp_inc >= (AW+1)'(cnt_ff)) begin
               rp_in = '0;
            end else begin
               rp_in = AW'(rp_inc);
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rp_ff        <= rp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      addr_ff <= addr_in;
      idx_ff  <= idx_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // assertions

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without preceding work");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transfer did not start work");

   a_next_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind_ff == OP_NEXT |-> rsp_data.hit)
      else $error("next result without hit");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && kind_ff == OP_NEXT && cnt_ff != '0 |-> rp_ff < cnt_ff)
      else $error("read pointer left beyond the count");

endmodule

[test/unique_address_set_table_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// unique_address_set_table_top_test
// self-checking bench for the unique address set table
// ----------------------------------------------------------------------------
// Drives insert, remove, lookup and round-robin read commands: a directed
// opening over the edge cases, then random bursts over small address pools
// and fill bursts that wrap the set at full depth. A shadow of the set
// predicts each result; the monitor compares every strobed result field by
// field in order. Command gaps come in random bursts, and the sender
// sometimes holds off until all outstanding results are back.
// ----------------------------------------------------------------------------
module unique_address_set_table_top_test;
   import uast_pkg::*;

   localparam int DEPTH        = SET_DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 850;
   localparam int CALM_TAIL    = 100;
   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct packed {
      req_type cmd;
      logic    wait_empty;
      logic    may_idle;
   } command_type;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   command_type commands_due[$];
   rsp_type     answers_due[$];
   rsp_type     want_rsp;

   // shadow of the set
   logic [ADDR_W-1:0] listed_addr[DEPTH];
   int listed_count = 0;
   int read_ptr     = 0;

   int mismatches   = 0;
   int transfers    = 0;
   int cycles       = 0;
   int idle_left    = 0;
   int n_new        = 0;
   int n_removed    = 0;
   int n_found      = 0;
   int n_reads      = 0;
   int n_wraps      = 0;
   int n_stale      = 0;
   int peak_count   = 0;

   unique_address_set_table_top #(
      .SET_DEPTH(DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic rsp_type next_set_answer(req_type cmd);
      rsp_type ans;
      int slot;
      int rp;
      int i;
      int j;
      ans  = '0;
      slot = -1;
      for (i = 0; i < listed_count && i < DEPTH; i++) begin
         if (slot < 0 && listed_addr[i] == cmd.address) slot = i;
      end
      case (cmd.kind)
         OP_INSERT: begin
            if (slot < 0) begin
               if (listed_count < DEPTH) listed_addr[listed_count] = cmd.address;
               listed_count++;
               ans.hit = 1'b1;
               n_new++;
            end
            if (listed_count > peak_count) peak_count = listed_count;
            if (listed_count >= DEPTH) begin
               listed_count = 0;
               n_wraps++;
            end
         end
         OP_REMOVE: begin
            if (slot >= 0) begin
               listed_count--;
               for (j = slot; j + 1 < DEPTH && j < listed_count; j++) begin
                  listed_addr[j] = listed_addr[j+1];
               end
               ans.hit = 1'b1;
               n_removed++;
            end
         end
         OP_LOOKUP: begin
            if (slot >= 0) begin
               ans.hit      = 1'b1;
               ans.position = POS_W'(slot);
               n_found++;
            end
         end
         default: begin
            rp = (read_ptr < DEPTH) ? read_ptr : 0;
            if (rp >= listed_count) n_stale++;
            ans.address_out = listed_addr[rp];
            ans.position    = POS_W'(rp);
            ans.hit         = 1'b1;
            rp++;
            if (rp >= listed_count) rp = 0;
            read_ptr = rp;
            n_reads++;
         end
      endcase
      ans.count = COUNT_W'(listed_count);
      return ans;
   endfunction

   task automatic add_command(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                              logic wait_empty, logic may_idle);
      command_type c;
      c.cmd.kind    = kind;
      c.cmd.address = addr;
      c.wait_empty  = wait_empty;
      c.may_idle    = may_idle;
      commands_due.push_back(c);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            answers_due.push_back(next_set_answer(req_data));
            commands_due.delete(0);
            transfers++;
            if (commands_due.size() > 0 && commands_due[0].may_idle &&
                $urandom_range(0, 3) == 0) idle_left = $urandom_range(1, 10);
         end
         if (!start || !busy) begin
            if (idle_left > 0) begin
               idle_left--;
               start <= 1'b0;
            end else if (commands_due.size() == 0) begin
               start <= 1'b0;
            end else if (commands_due[0].wait_empty && answers_due.size() != 0) begin
               start <= 1'b0;
            end else begin
               start    <= 1'b1;
               req_data <= commands_due[0].cmd;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (answers_due.size() == 0) begin
            $error("result with none outstanding: %p", rsp_data);
            mismatches++;
         end else begin
            want_rsp = answers_due.pop_front();
            if (rsp_data.hit !== want_rsp.hit) begin
               $error("hit: expected %0d, got %0d", want_rsp.hit, rsp_data.hit);
               mismatches++;
            end
            if (rsp_data.position !== want_rsp.position) begin
               $error("position: expected %0d, got %0d", want_rsp.position,
                      rsp_data.position);
               mismatches++;
            end
            if (rsp_data.address_out !== want_rsp.address_out) begin
               $error("address_out: expected %0h, got %0h", want_rsp.address_out,
                      rsp_data.address_out);
               mismatches++;
            end
            if (rsp_data.count !== want_rsp.count) begin
               $error("count: expected %0d, got %0d", want_rsp.count, rsp_data.count);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $error("run stopped after %0d cycles with %0d transfers", cycles, transfers);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int n;
      int k;
      int len;
      int pick;
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] addr;
      logic [KIND_W-1:0] kind;
      logic idle_ok;
      logic gate;

      for (k = 0; k < DEPTH; k++) listed_addr[k] = '0;

      // empty set, extremes, duplicates, stale slot after remove
      add_command(OP_NEXT,   8'h00, 1'b0, 1'b0);
      add_command(OP_LOOKUP, 8'h00, 1'b0, 1'b0);
      add_command(OP_REMOVE, 8'hff, 1'b0, 1'b0);
      add_command(OP_INSERT, 8'h00, 1'b0, 1'b0);
      add_command(OP_INSERT, 8'hff, 1'b0, 1'b0);
      add_command(OP_INSERT, 8'h00, 1'b0, 1'b0);
      add_command(OP_INSERT, 8'h5a, 1'b0, 1'b0);
      add_command(OP_INSERT, 8'ha5, 1'b0, 1'b1);
      add_command(OP_LOOKUP, 8'hff, 1'b0, 1'b1);
      add_command(OP_LOOKUP, 8'ha5, 1'b0, 1'b0);
      add_command(OP_LOOKUP, 8'h3c, 1'b0, 1'b0);
      add_command(OP_NEXT,   8'h00, 1'b0, 1'b0);
      add_command(OP_NEXT,   8'hff, 1'b0, 1'b1);
      add_command(OP_NEXT,   8'h00, 1'b0, 1'b0);
      add_command(OP_REMOVE, 8'hff, 1'b0, 1'b0);
      add_command(OP_NEXT,   8'h00, 1'b0, 1'b0);
      add_command(OP_NEXT,   8'h00, 1'b0, 1'b0);
      add_command(OP_REMOVE, 8'h00, 1'b0, 1'b1);
      add_command(OP_REMOVE, 8'ha5, 1'b0, 1'b0);
      add_command(OP_LOOKUP, 8'h5a, 1'b0, 1'b0);
      add_command(OP_REMOVE, 8'h5a, 1'b0, 1'b0);
      add_command(OP_NEXT,   8'h00, 1'b0, 1'b0);
      add_command(OP_INSERT, 8'h80, 1'b0, 1'b0);
      add_command(OP_INSERT, 8'h01, 1'b0, 1'b0);

      n = 0;
      while (n < RANDOM_ITEMS) begin
         idle_ok = ($urandom_range(0, 2) != 0);
         gate    = (n == 0) || ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 7) == 0) begin
            // distinct addresses, enough to wrap the set
            base = ADDR_W'($urandom_range(0, 255));
            for (k = 0; k < DEPTH + 2; k++) begin
               add_command(OP_INSERT, ADDR_W'(base + 7 * k), gate && k == 0,
                           idle_ok && n < RANDOM_ITEMS - CALM_TAIL);
               n++;
            end
         end else begin
            base = ADDR_W'($urandom_range(0, 255));
            len  = $urandom_range(15, 40);
            for (k = 0; k < len; k++) begin
               pick = $urandom_range(0, 99);
               if ($urandom_range(0, 9) < 7) addr = ADDR_W'(base + $urandom_range(0, 15));
               else addr = ADDR_W'($urandom_range(0, 255));
               if (pick < 40) kind = OP_INSERT;
               else if (pick < 60) kind = OP_REMOVE;
               else if (pick < 80) kind = OP_LOOKUP;
               else kind = OP_NEXT;
               add_command(kind, addr, gate && k == 0,
                           idle_ok && n < RANDOM_ITEMS - CALM_TAIL);
               n++;
            end
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (commands_due.size() != 0 || start) @(posedge clock);
      while (answers_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d transfers: %0d new inserts, %0d removals, %0d lookup hits, %0d reads",
               transfers, n_new, n_removed, n_found, n_reads);
      $display("set filled to depth %0d times, peak fill %0d, %0d reads past the list end",
               n_wraps, peak_count, n_stale);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
